[hdl/btpc_pkg.sv]
// ----------------------------------------------------------------------------
// btpc_pkg
// Shared types and constants of the barometric compensation pipeline.
// ----------------------------------------------------------------------------
package btpc_pkg;

  localparam int RawW    = 20;
  localparam int TempW   = 15;
  localparam int PressW  = 32;
  localparam int DivBits = 64;   // quotient bits, one per divider stage
  localparam int DenW    = 31;   // divisor magnitude is at most 2**30

  localparam int TempMin  = -4000;
  localparam int TempMax  = 8500;
  localparam int TFineOff = 128000;
  localparam int PBase    = 1048576;
  localparam int NumScale = 3125;

  localparam logic [63:0] OneQ47 = 64'h0000_8000_0000_0000;

  // register indexes on the config port
  localparam logic [1:0] RegCalTemp   = 2'd0;
  localparam logic [1:0] RegCalPressA = 2'd1;
  localparam logic [1:0] RegCalPressB = 2'd2;
  localparam logic [1:0] RegCalPressC = 2'd3;

  // sideband that rides along with the quotient
  typedef struct packed {
    logic                    q_neg;
    logic                    dz;
    logic signed [TempW-1:0] temp;
  } side_t;

endpackage

[hdl/btpc_if.sv]
// ----------------------------------------------------------------------------
// btpc_if
// Valid/ready channels for raw sample pairs and compensated results.
// ----------------------------------------------------------------------------
interface btpc_smp_if;
  logic        valid;
  logic        ready;
  logic [19:0] raw_temperature;
  logic [19:0] raw_pressure;

  modport source (output valid, output raw_temperature, output raw_pressure, input ready);
  modport sink   (input valid, input raw_temperature, input raw_pressure, output ready);
endinterface

interface btpc_res_if;
  logic               valid;
  logic               ready;
  logic signed [14:0] temperature_centi;
  logic [31:0]        pressure_q24_8;
  logic               divisor_zero;

  modport source (output valid, output temperature_centi, output pressure_q24_8,
                  output divisor_zero, input ready);
  modport sink   (input valid, input temperature_centi, input pressure_q24_8,
                  input divisor_zero, output ready);
endinterface

[hdl/btpc_div.sv]
// ----------------------------------------------------------------------------
// btpc_div
// Pipelined unsigned 64 / 31 bit restoring divider, one quotient bit a stage.
// ----------------------------------------------------------------------------
module btpc_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           vld_i,
  input  logic [63:0]                    num_i,
  input  logic [btpc_pkg::DenW-1:0]      den_i,
  input  btpc_pkg::side_t                side_i,
  output logic                           vld_o,
  output logic [63:0]                    quo_o,
  output btpc_pkg::side_t                side_o
);

  localparam int N = btpc_pkg::DivBits;
  localparam int W = btpc_pkg::DenW;

  logic [N-1:0]    vld_q;
  logic [W-1:0]    rem_q [N];
  logic [63:0]     n_q   [N];
  logic [W-1:0]    den_q [N];
  btpc_pkg::side_t side_q [N];

  logic [W-1:0]    rem_d [N];
  logic [63:0]     n_d   [N];

  always_comb begin
    logic [W-1:0] r_in;
    logic [63:0]  n_in;
    logic [W-1:0] d_in;
    logic [W:0]   tr;
    logic         ge;
    for (int k = 0; k < N; k++) begin
      r_in = (k == 0) ? '0 : rem_q[(k == 0) ? 0 : k-1];
      n_in = (k == 0) ? num_i : n_q[(k == 0) ? 0 : k-1];
      d_in = (k == 0) ? den_i : den_q[(k == 0) ? 0 : k-1];
      tr   = {r_in, n_in[63]};
      ge   = (tr >= {1'b0, d_in});
      rem_d[k] = ge ? W'(tr - {1'b0, d_in}) : W'(tr);
      n_d[k]   = {n_in[62:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[N-2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < N; k++) begin
        rem_q[k] <= rem_d[k];
        n_q[k]   <= n_d[k];
      end
      den_q[0]  <= den_i;
      side_q[0] <= side_i;
      for (int k = 1; k < N; k++) begin
        den_q[k]  <= den_q[k-1];
        side_q[k] <= side_q[k-1];
      end
    end
  end

  assign vld_o  = vld_q[N-1];
  assign quo_o  = n_q[N-1];
  assign side_o = side_q[N-1];

endmodule

[hdl/baro_temp_pressure_compensation_top.sv]
// ----------------------------------------------------------------------------
// baro_temp_pressure_compensation_top
// Integer temperature and pressure compensation of a barometric sensor.
// ----------------------------------------------------------------------------
// Usage:
//   smp_i carries raw 20-bit temperature / pressure pairs, res_o returns the
//   temperature in 0.01 C (clamped to -4000..8500) and pressure in Pa, Q24.8.
//   divisor_zero flags a zero pressure divisor; pressure then reads 0.
//   Calibration words are written on the APB port (8-byte stride) while idle.
//   Throughput: one transaction per cycle while the skid register is empty.
//   A transaction passes 13 front stages, the 64-stage quotient pipeline,
//   6 back stages of split 32-bit multiplies and the output register.
//   Reset clears all valid bits and the calibration registers; no item is
//   in flight afterwards and smp_i.ready comes up high.
//   When res_o stalls, the pending result holds in the output register and
//   one more lands in a skid register; only then does the whole pipeline
//   freeze and smp_i.ready drop, so no transaction is lost or repeated.
// ----------------------------------------------------------------------------
module baro_temp_pressure_compensation_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  btpc_smp_if.sink    smp_i,
  btpc_res_if.source  res_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam int TW = btpc_pkg::TempW;

  // ---------------- configuration ----------------
  logic [47:0] cal_temp_q;
  logic [63:0] cal_press_a_q;
  logic [63:0] cal_press_b_q;
  logic [15:0] cal_press_c_q;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_temp_q    <= '0;
      cal_press_a_q <= '0;
      cal_press_b_q <= '0;
      cal_press_c_q <= '0;
    end else if (wr_en) begin
      case (paddr[4:3])
        btpc_pkg::RegCalTemp:   cal_temp_q    <= pwdata[47:0];
        btpc_pkg::RegCalPressA: cal_press_a_q <= pwdata;
        btpc_pkg::RegCalPressB: cal_press_b_q <= pwdata;
        btpc_pkg::RegCalPressC: cal_press_c_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:3])
      btpc_pkg::RegCalTemp:   prdata = {16'b0, cal_temp_q};
      btpc_pkg::RegCalPressA: prdata = cal_press_a_q;
      btpc_pkg::RegCalPressB: prdata = cal_press_b_q;
      btpc_pkg::RegCalPressC: prdata = {48'b0, cal_press_c_q};
      default:                prdata = '0;
    endcase
  end

  logic [15:0]        t1, p1;
  logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;

  assign t1 = cal_temp_q[15:0];
  assign t2 = signed'(cal_temp_q[31:16]);
  assign t3 = signed'(cal_temp_q[47:32]);
  assign p1 = cal_press_a_q[15:0];
  assign p2 = signed'(cal_press_a_q[31:16]);
  assign p3 = signed'(cal_press_a_q[47:32]);
  assign p4 = signed'(cal_press_a_q[63:48]);
  assign p5 = signed'(cal_press_b_q[15:0]);
  assign p6 = signed'(cal_press_b_q[31:16]);
  assign p7 = signed'(cal_press_b_q[47:32]);
  assign p8 = signed'(cal_press_b_q[63:48]);
  assign p9 = signed'(cal_press_c_q);

  // ---------------- flow control ----------------
  logic en, skid_vld_q, out_vld_q, take;
  logic last_vld;

  assign en          = !skid_vld_q;
  assign smp_i.ready = en;
  assign take        = out_vld_q && res_o.ready;

  // ---------------- front stages S1..S13 ----------------
  logic [13:1] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[12:1], smp_i.valid};
    end
  end

  logic signed [17:0]  s1_d1_q, s1_d2_q;
  logic [19:0]         adcp_q [1:9];
  logic signed [31:0]  s2_ma_q, s2_sq_q;
  logic signed [31:0]  s3_a_q, s3_mb_q;
  logic signed [31:0]  s4_fine_q;
  logic signed [TW-1:0] tmp_q [5:12];
  logic signed [32:0]  s5_v1_q;
  logic [63:0]         s6_sq_q;
  logic signed [48:0]  s6_v1p5_q, s6_v1p2_q;
  logic signed [48:0]  s7_p6lo_q, s7_p3lo_q, s7_v1p5_q, s7_v1p2_q;
  logic [31:0]         s7_p6hi_q, s7_p3hi_q;
  logic signed [63:0]  s8_sqp6_q, s8_sqp3_q;
  logic signed [48:0]  s8_v1p5_q, s8_v1p2_q;
  logic signed [63:0]  s9_v2_q;
  logic [63:0]         s9_y_q;
  logic [47:0]         s10_ylo_q;
  logic [31:0]         s10_yhi_q;
  logic [63:0]         s10_nm_q;
  logic signed [30:0]  s11_v1f_q;
  logic [43:0]         s11_nlo_q;
  logic [31:0]         s11_nhi_q;
  logic [63:0]         s12_num_q;
  logic [30:0]         s12_dmag_q;
  logic                s12_dneg_q, s12_dz_q;
  logic [63:0]         s13_nmag_q;
  logic [30:0]         s13_dmag_q;
  btpc_pkg::side_t     s13_side_q;

  logic signed [33:0]  ma_w;
  logic signed [35:0]  sq_w;
  logic signed [47:0]  mb_w;
  logic signed [31:0]  t5_w;
  logic signed [TW-1:0] clamp_w;
  logic signed [65:0]  sq64_w;
  logic signed [48:0]  v1p5_w, v1p2_w, p6lo_w, p3lo_w;
  logic [20:0]         pv_w;
  logic [63:0]         yfull_w;
  logic signed [63:0]  num_w;

  always_comb begin
    ma_w   = s1_d1_q * t2;
    sq_w   = s1_d2_q * s1_d2_q;
    mb_w   = (s2_sq_q >>> 12) * t3;
    t5_w   = (s4_fine_q + (s4_fine_q <<< 2) + 32'sd128) >>> 8;
    if (t5_w < 32'(btpc_pkg::TempMin)) begin
      clamp_w = TW'(btpc_pkg::TempMin);
    end else if (t5_w > 32'(btpc_pkg::TempMax)) begin
      clamp_w = TW'(btpc_pkg::TempMax);
    end else begin
      clamp_w = t5_w[TW-1:0];
    end
    sq64_w  = s5_v1_q * s5_v1_q;
    v1p5_w  = s5_v1_q * p5;
    v1p2_w  = s5_v1_q * p2;
    p6lo_w  = signed'({1'b0, s6_sq_q[31:0]}) * p6;
    p3lo_w  = signed'({1'b0, s6_sq_q[31:0]}) * p3;
    pv_w    = 21'(btpc_pkg::PBase) - {1'b0, adcp_q[9]};
    yfull_w = {s10_yhi_q, 32'b0} + {16'b0, s10_ylo_q};
    num_w   = signed'({s11_nhi_q, 32'b0} + {20'b0, s11_nlo_q});
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      // S1
      s1_d1_q   <= 18'({1'b0, smp_i.raw_temperature[19:3]}) - 18'({t1, 1'b0});
      s1_d2_q   <= 18'({2'b0, smp_i.raw_temperature[19:4]}) - 18'({2'b0, t1});
      adcp_q[1] <= smp_i.raw_pressure;
      for (int k = 2; k <= 9; k++) adcp_q[k] <= adcp_q[k-1];
      // S2
      s2_ma_q <= ma_w[31:0];
      s2_sq_q <= sq_w[31:0];
      // S3
      s3_a_q  <= s2_ma_q >>> 11;
      s3_mb_q <= mb_w[31:0];
      // S4
      s4_fine_q <= s3_a_q + (s3_mb_q >>> 14);
      // S5
      tmp_q[5] <= clamp_w;
      for (int k = 6; k <= 12; k++) tmp_q[k] <= tmp_q[k-1];
      s5_v1_q  <= 33'(s4_fine_q) - 33'(btpc_pkg::TFineOff);
      // S6
      s6_sq_q   <= sq64_w[63:0];
      s6_v1p5_q <= v1p5_w;
      s6_v1p2_q <= v1p2_w;
      // S7: split 64 x 16 products
      s7_p6lo_q <= p6lo_w;
      s7_p3lo_q <= p3lo_w;
      s7_p6hi_q <= 32'(s6_sq_q[63:32] * 32'(p6));
      s7_p3hi_q <= 32'(s6_sq_q[63:32] * 32'(p3));
      s7_v1p5_q <= s6_v1p5_q;
      s7_v1p2_q <= s6_v1p2_q;
      // S8
      s8_sqp6_q <= signed'({s7_p6hi_q, 32'b0}) + 64'(s7_p6lo_q);
      s8_sqp3_q <= signed'({s7_p3hi_q, 32'b0}) + 64'(s7_p3lo_q);
      s8_v1p5_q <= s7_v1p5_q;
      s8_v1p2_q <= s7_v1p2_q;
      // S9
      s9_v2_q <= s8_sqp6_q + (64'(s8_v1p5_q) <<< 17) + (64'(p4) <<< 35);
      s9_y_q  <= 64'(s8_sqp3_q >>> 8) + 64'(64'(s8_v1p2_q) <<< 12) + btpc_pkg::OneQ47;
      // S10
      s10_ylo_q <= s9_y_q[31:0] * p1;
      s10_yhi_q <= 32'(s9_y_q[63:32] * {16'b0, p1});
      s10_nm_q  <= (64'(pv_w) << 31) - 64'(s9_v2_q);
      // S11
      s11_v1f_q <= signed'(yfull_w[63:33]);
      s11_nlo_q <= s10_nm_q[31:0] * 12'(btpc_pkg::NumScale);
      s11_nhi_q <= 32'(s10_nm_q[63:32] * 32'(btpc_pkg::NumScale));
      // S12
      s12_num_q  <= num_w;
      s12_dz_q   <= (s11_v1f_q == '0);
      s12_dneg_q <= s11_v1f_q[30];
      s12_dmag_q <= s11_v1f_q[30] ? 31'(-s11_v1f_q) : 31'(s11_v1f_q);
      // S13
      s13_nmag_q       <= s12_num_q[63] ? (64'd0 - s12_num_q) : s12_num_q;
      s13_dmag_q       <= s12_dmag_q;
      s13_side_q.q_neg <= s12_num_q[63] ^ s12_dneg_q;
      s13_side_q.dz    <= s12_dz_q;
      s13_side_q.temp  <= tmp_q[12];
    end
  end

  // ---------------- divider ----------------
  logic            div_vld;
  logic [63:0]     div_quo;
  btpc_pkg::side_t div_side;

  btpc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (vld_q[13]),
    .num_i  (s13_nmag_q),
    .den_i  (s13_dmag_q),
    .side_i (s13_side_q),
    .vld_o  (div_vld),
    .quo_o  (div_quo),
    .side_o (div_side)
  );

  // ---------------- back stages Q0..Q5 ----------------
  logic [5:0]          qv_q;
  btpc_pkg::side_t     qside_q [6];
  logic signed [63:0]  q0_qf_q, q1_qf_q, q2_qf_q, q3_qf_q, q4_qf_q;
  logic signed [63:0]  q1_s_q, q2_s_q;
  logic signed [48:0]  q1_s9lo_q, q1_q8lo_q;
  logic [31:0]         q1_s9hi_q, q1_q8hi_q;
  logic [63:0]         q2_m1_q;
  logic signed [63:0]  q2_b_q, q3_b_q, q4_b_q;
  logic [63:0]         q3_pp0_q;
  logic [31:0]         q3_pp1_q, q3_pp2_q;
  logic signed [63:0]  q4_a_q;
  logic signed [63:0]  q5_sum_q;

  logic signed [63:0]  sh13_w, bp_w, prod_w;
  logic signed [48:0]  s9lo_w, q8lo_w;

  always_comb begin
    sh13_w = q0_qf_q >>> 13;
    s9lo_w = signed'({1'b0, sh13_w[31:0]}) * p9;
    q8lo_w = signed'({1'b0, q0_qf_q[31:0]}) * p8;
    bp_w   = signed'({q1_q8hi_q, 32'b0}) + 64'(q1_q8lo_q);
    prod_w = signed'(q3_pp0_q + {32'(q3_pp1_q + q3_pp2_q), 32'b0});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qv_q <= '0;
    end else if (en) begin
      qv_q <= {qv_q[4:0], div_vld};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      qside_q[0] <= div_side;
      for (int k = 1; k < 6; k++) qside_q[k] <= qside_q[k-1];
      // Q0: restore quotient sign
      q0_qf_q   <= div_side.q_neg ? signed'(64'd0 - div_quo) : signed'(div_quo);
      // Q1: split products by p9 and p8
      q1_qf_q   <= q0_qf_q;
      q1_s_q    <= sh13_w;
      q1_s9lo_q <= s9lo_w;
      q1_s9hi_q <= 32'(sh13_w[63:32] * 32'(p9));
      q1_q8lo_q <= q8lo_w;
      q1_q8hi_q <= 32'(q0_qf_q[63:32] * 32'(p8));
      // Q2
      q2_qf_q <= q1_qf_q;
      q2_s_q  <= q1_s_q;
      q2_m1_q <= {q1_s9hi_q, 32'b0} + 64'(q1_s9lo_q);
      q2_b_q  <= bp_w >>> 19;
      // Q3: low 64 bits of m1 * s from three 32x32 products
      q3_qf_q  <= q2_qf_q;
      q3_b_q   <= q2_b_q;
      q3_pp0_q <= q2_m1_q[31:0] * q2_s_q[31:0];
      q3_pp1_q <= 32'(q2_m1_q[31:0] * q2_s_q[63:32]);
      q3_pp2_q <= 32'(q2_m1_q[63:32] * q2_s_q[31:0]);
      // Q4
      q4_qf_q <= q3_qf_q;
      q4_b_q  <= q3_b_q;
      q4_a_q  <= prod_w >>> 25;
      // Q5
      q5_sum_q <= q4_qf_q + q4_a_q + q4_b_q;
    end
  end

  // ---------------- output register and skid ----------------
  logic [31:0] press_w;
  logic [31:0] out_press_q, skid_press_q;
  logic signed [TW-1:0] out_temp_q, skid_temp_q;
  logic        out_dz_q, skid_dz_q;
  logic        load_out, load_skid, out_from_skid;

  assign last_vld = qv_q[5];
  assign press_w  = qside_q[5].dz ? '0
                  : (q5_sum_q[39:8] + {{12{p7[15]}}, p7, 4'b0});

  assign out_from_skid = skid_vld_q && take;
  assign load_out      = !skid_vld_q && last_vld && (!out_vld_q || take);
  assign load_skid     = !skid_vld_q && last_vld && out_vld_q && !take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (out_from_skid) begin
        skid_vld_q <= 1'b0;
      end else if (load_skid) begin
        skid_vld_q <= 1'b1;
      end
      if (out_from_skid || load_out) begin
        out_vld_q <= 1'b1;
      end else if (take) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_from_skid) begin
      out_press_q <= skid_press_q;
      out_temp_q  <= skid_temp_q;
      out_dz_q    <= skid_dz_q;
    end else if (load_out) begin
      out_press_q <= press_w;
      out_temp_q  <= qside_q[5].temp;
      out_dz_q    <= qside_q[5].dz;
    end
    if (load_skid) begin
      skid_press_q <= press_w;
      skid_temp_q  <= qside_q[5].temp;
      skid_dz_q    <= qside_q[5].dz;
    end
  end

  assign res_o.valid             = out_vld_q;
  assign res_o.temperature_centi = out_temp_q;
  assign res_o.pressure_q24_8    = out_press_q;
  assign res_o.divisor_zero      = out_dz_q;

endmodule

[hdl/btpc_checker.sv]
// ----------------------------------------------------------------------------
// btpc_checker
// Port-level checks on the compensation block's result channel.
// ----------------------------------------------------------------------------
module btpc_checker (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  out_valid_i,
  input logic                                  out_ready_i,
  input logic signed [btpc_pkg::TempW-1:0]     temp_i,
  input logic [31:0]                           press_i,
  input logic                                  dz_i
);

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result valid dropped while stalled");

  a_temp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (temp_i >= btpc_pkg::TempW'(btpc_pkg::TempMin)) &&
                    (temp_i <= btpc_pkg::TempW'(btpc_pkg::TempMax)))
    else $error("temperature outside clamp range");

  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && dz_i |-> press_i == '0)
    else $error("pressure nonzero with zero divisor");

  a_payload_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(press_i) && $stable(temp_i) && $stable(dz_i))
    else $error("result payload changed while stalled");

endmodule

bind baro_temp_pressure_compensation_top btpc_checker u_btpc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .temp_i      (res_o.temperature_centi),
  .press_i     (res_o.pressure_q24_8),
  .dz_i        (res_o.divisor_zero)
);
